>>> rtl/cpwc_pkg.sv
// cpwc_pkg: constants, types and helper functions of the cascaded wheel controller
// no dependencies; used by all rtl modules, not by the interfaces
package cpwc_pkg;

  localparam int TARGET_POSITION = 2500;
  localparam int MIN_PERIOD_MS   = 50;
  localparam int GOAL_TOLERANCE  = 10;
  localparam int VT_LIMIT        = 600;
  localparam int DRIVE_LIMIT     = 1023;
  localparam int INTEG_LIMIT     = 1000 * 65536;

  // integrator increment |ev| * ms * 8192 / 125 = 65 * n + n * 67 / 125
  // n * 67 / 125 is taken as (n * INC_RECIP) >> RCP_SHIFT, exact for n below 2^INC_N_W
  // from 2^INC_N_W up the increment alone is past twice the limit, so it saturates
  localparam int INC_N_W      = 21;
  localparam int INC_SAT_PROD = 2 ** INC_N_W;
  localparam int INC_RECIP    = 143881405;
  localparam int RCP_SHIFT    = 28;
  localparam int INC_SAT      = 2 * INTEG_LIMIT;

  localparam int GAIN_W = 24;
  localparam int NREG   = 8;
  localparam int IDX_W  = 3;
  localparam int MA_W   = 34;
  localparam int MB_W   = 24;
  localparam int MP_W   = MA_W + MB_W;
  localparam int DW     = 68;
  localparam int DVS_W  = 17;
  localparam int CNT_W  = 7;
  localparam int INT_W  = 28;
  localparam int ERR_W  = 33;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [IDX_W-1:0] REG_POS_KP_A = 3'd0;
  localparam logic [IDX_W-1:0] REG_POS_KD_A = 3'd1;
  localparam logic [IDX_W-1:0] REG_POS_KP_B = 3'd2;
  localparam logic [IDX_W-1:0] REG_POS_KD_B = 3'd3;
  localparam logic [IDX_W-1:0] REG_VEL_KP_A = 3'd4;
  localparam logic [IDX_W-1:0] REG_VEL_KI_A = 3'd5;
  localparam logic [IDX_W-1:0] REG_VEL_KP_B = 3'd6;
  localparam logic [IDX_W-1:0] REG_VEL_KI_B = 3'd7;

  localparam logic [GAIN_W-1:0] CFG_RESET [NREG] = '{
    24'd196608, 24'd327680, 24'd0, 24'd0, 24'd0, 24'd0, 24'd196608, 24'd655
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_MUL_P, ST_MUL_D, ST_X1000, ST_DIV_D, ST_VT, ST_MUL_I,
    ST_START_I, ST_DIV_I, ST_MUL_KP, ST_MUL_KI, ST_DRIVE, ST_OUT1, ST_OUT2, ST_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DW-1:0]    dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  function automatic logic [MA_W-1:0] abs34(input logic signed [MA_W-1:0] x);
    abs34 = x[MA_W-1] ? -x : x;
  endfunction

  // divide by 65536, rounding toward zero
  function automatic logic signed [63:0] tdiv16(input logic signed [63:0] x);
    logic [63:0] m;
    m = x[63] ? -x : x;
    m = m >> 16;
    tdiv16 = x[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [63:0] x,
                                              input logic signed [63:0] lim);
    if (x > lim) sat64 = lim;
    else if (x < -lim) sat64 = -lim;
    else sat64 = x;
  endfunction

endpackage

>>> rtl/cpwc_in_if.sv
// cpwc_in_if: input item channel, valid/ready plus command payload
// depends on nothing
interface cpwc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [2:0]         motion_code;
  logic signed [31:0] encoder_a;
  logic signed [31:0] encoder_b;
  logic [15:0]        elapsed_ms;
  modport source(output valid, command, motion_code, encoder_a, encoder_b, elapsed_ms,
                 input ready);
  modport sink(input valid, command, motion_code, encoder_a, encoder_b, elapsed_ms,
               output ready);
endinterface

>>> rtl/cpwc_out_if.sv
// cpwc_out_if: result channel, valid/ready plus result payload
// depends on nothing
interface cpwc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         motion_out;
  logic signed [10:0] drive_a;
  logic signed [10:0] drive_b;
  logic               step_done;
  logic               all_finished;
  logic               last;
  modport source(output valid, motion_out, drive_a, drive_b, step_done, all_finished, last,
                 input ready);
  modport sink(input valid, motion_out, drive_a, drive_b, step_done, all_finished, last,
               output ready);
endinterface

>>> rtl/cpwc_cfg_if.sv
// cpwc_cfg_if: gain register write channel, valid/ready plus index and data
// depends on nothing
interface cpwc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/cpwc_mul.sv
// cpwc_mul: shared unsigned multiplier with registered product
// depends on cpwc_pkg
module cpwc_mul (
  input  logic                      clk,
  input  logic [cpwc_pkg::MA_W-1:0] a,
  input  logic [cpwc_pkg::MB_W-1:0] b,
  output logic [cpwc_pkg::MP_W-1:0] prod
);
  import cpwc_pkg::*;

  logic [MP_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= MP_W'(a) * MP_W'(b);
  end

  assign prod = prod_r;
endmodule

>>> rtl/cpwc_div.sv
// cpwc_div: shared restoring divider, one quotient bit per cycle
// depends on cpwc_pkg
module cpwc_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cpwc_pkg::div_req_t      req,
  output logic                    busy,
  output logic [cpwc_pkg::DW-1:0] quotient
);
  import cpwc_pkg::*;

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic             ge;

  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;
endmodule

>>> rtl/cascaded_pd_pi_wheel_controller_top.sv
// cascaded_pd_pi_wheel_controller_top: two-wheel position pd / velocity pi controller
// a control tick works through wheel a, then wheel b, and then offers its results; each
// wheel waits on the 68-step serial divider (derivative over elapsed time)
// one item at a time: a new item is taken only while idle, once the last results are taken
// reset (synchronous, rst_n low): idle, not running, gains at default values
// depends on cpwc_pkg, the three channel interfaces, cpwc_mul and cpwc_div
module cascaded_pd_pi_wheel_controller_top (
  input  logic clk,
  input  logic rst_n,
  cpwc_in_if.sink    in_ch,
  cpwc_out_if.source out_ch,
  cpwc_cfg_if.sink   cfg_ch
);
  import cpwc_pkg::*;

  state_t state_r, state_nxt;

  // gain registers
  logic [GAIN_W-1:0] cfg_r [NREG];

  // loop state
  logic                    running_r;
  logic [2:0]              motion_r;
  logic [16:0]             accum_r;
  logic [16:0]             ms_r;
  logic                    wsel_r;
  logic                    done_r;
  logic [31:0]             enc_r      [2];
  logic [31:0]             prev_enc_r [2];
  logic signed [ERR_W-1:0] prev_err_r [2];
  logic signed [INT_W-1:0] integ_r    [2];
  logic signed [10:0]      drive_r    [2];

  // per-wheel working registers
  logic signed [MA_W-1:0] e_r, de_r, ev_r;
  logic signed [31:0]     ds_r;
  logic signed [63:0]     p_r, t1_r;
  logic [MP_W-1:0]        iprod_r;

  // shared units
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [MP_W-1:0] prod;
  div_req_t        dreq;
  logic            div_busy;
  logic [DW-1:0]   quo;

  cpwc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
  cpwc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(div_busy), .quotient(quo));

  logic in_xfer, out_xfer;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  logic [16:0] acc_sum;
  assign acc_sum = accum_r + {1'b0, in_ch.elapsed_ms};

  // gains of the wheel being worked on
  logic [GAIN_W-1:0] kp, kd, vkp, vki;
  always_comb begin
    kp  = wsel_r ? cfg_r[REG_POS_KP_B] : cfg_r[REG_POS_KP_A];
    kd  = wsel_r ? cfg_r[REG_POS_KD_B] : cfg_r[REG_POS_KD_A];
    vkp = wsel_r ? cfg_r[REG_VEL_KP_B] : cfg_r[REG_VEL_KP_A];
    vki = wsel_r ? cfg_r[REG_VEL_KI_B] : cfg_r[REG_VEL_KI_A];
  end

  // position error, its change and the encoder delta
  logic [31:0]             enc_cur;
  logic signed [MA_W-1:0]  enc_x, e_cmb, de_cmb;
  logic signed [31:0]      ds_cmb;
  always_comb begin
    enc_cur = enc_r[wsel_r];
    enc_x   = {{2{enc_cur[31]}}, enc_cur};
    e_cmb   = MA_W'(TARGET_POSITION) - $signed(abs34(enc_x));
    de_cmb  = e_cmb - {prev_err_r[wsel_r][ERR_W-1], prev_err_r[wsel_r]};
    ds_cmb  = $signed(enc_cur - prev_enc_r[wsel_r]);
  end

  // product as signed 64 bit value
  logic signed [63:0] prod_s;
  assign prod_s = $signed({{(64-MP_W){1'b0}}, prod});

  // velocity target and velocity error from the pd term
  logic signed [63:0]     d_mag, d_sig, pos_q16, vt;
  logic signed [MA_W-1:0] ev_cmb;
  always_comb begin
    d_mag   = $signed({1'b0, quo[62:0]});
    d_sig   = de_r[MA_W-1] ? -d_mag : d_mag;
    pos_q16 = p_r + d_sig;
    vt      = sat64(tdiv16(pos_q16), 64'(VT_LIMIT));
    ev_cmb  = vt[MA_W-1:0] - {{(MA_W-32){ds_r[31]}}, ds_r};
  end

  // integrator update; iprod_r is |ev| * ms, prod holds its low bits times the reciprocal
  logic [MP_W-1:0]    inc_q;
  logic signed [63:0] inc_mag, inc_sig, isum, integ_new;
  always_comb begin
    inc_q     = (iprod_r << 6) + iprod_r + (prod >> RCP_SHIFT);
    inc_mag   = (iprod_r >= MP_W'(INC_SAT_PROD)) ? 64'(INC_SAT) :
                $signed({{(64-MP_W){1'b0}}, inc_q});
    inc_sig   = ev_r[MA_W-1] ? -inc_mag : inc_mag;
    isum      = {{(64-INT_W){integ_r[wsel_r][INT_W-1]}}, integ_r[wsel_r]} + inc_sig;
    integ_new = sat64(isum, 64'(INTEG_LIMIT));
  end

  // drive from the pi term
  logic signed [63:0] t2, drv;
  logic               wheel_ok;
  always_comb begin
    t2       = tdiv16(integ_r[wsel_r][INT_W-1] ? -prod_s : prod_s);
    drv      = sat64(tdiv16(t1_r + t2), 64'(DRIVE_LIMIT));
    wheel_ok = abs34(e_r) <= MA_W'(GOAL_TOLERANCE);
  end

  // shared unit operand select
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = ms_r;
    case (state_r)
      ST_MUL_P: begin
        mul_a = abs34(e_r);
        mul_b = kp;
      end
      ST_MUL_D: begin
        mul_a = abs34(de_r);
        mul_b = kd;
      end
      ST_X1000: begin
        // m * 1000 as shifts
        dreq.start    = 1'b1;
        dreq.dividend = (DW'(prod) << 10) - (DW'(prod) << 4) - (DW'(prod) << 3);
      end
      ST_MUL_I: begin
        mul_a = abs34(ev_r);
        mul_b = {{(MB_W-17){1'b0}}, ms_r};
      end
      ST_START_I: begin
        // fraction of the increment by reciprocal multiplication
        mul_a = MA_W'(INC_RECIP);
        mul_b = {{(MB_W-INC_N_W){1'b0}}, prod[INC_N_W-1:0]};
      end
      ST_MUL_KP: begin
        mul_a = abs34(ev_r);
        mul_b = vkp;
      end
      ST_MUL_KI: begin
        mul_a = abs34({{(MA_W-INT_W){integ_r[wsel_r][INT_W-1]}}, integ_r[wsel_r]});
        mul_b = vki;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (!running_r && in_ch.command == CMD_FINISH) state_nxt = ST_FIN;
          else if (running_r && in_ch.command == CMD_TICK &&
                   acc_sum >= 17'(MIN_PERIOD_MS)) state_nxt = ST_PREP;
        end
      end
      ST_PREP:    state_nxt = ST_MUL_P;
      ST_MUL_P:   state_nxt = ST_MUL_D;
      ST_MUL_D:   state_nxt = ST_X1000;
      ST_X1000:   state_nxt = ST_DIV_D;
      ST_DIV_D:   if (!div_busy) state_nxt = ST_VT;
      ST_VT:      state_nxt = ST_MUL_I;
      ST_MUL_I:   state_nxt = ST_START_I;
      ST_START_I: state_nxt = ST_DIV_I;
      ST_DIV_I:   state_nxt = ST_MUL_KP;
      ST_MUL_KP:  state_nxt = ST_MUL_KI;
      ST_MUL_KI:  state_nxt = ST_DRIVE;
      ST_DRIVE:   state_nxt = wsel_r ? ST_OUT1 : ST_PREP;
      ST_OUT1:    if (out_xfer) state_nxt = done_r ? ST_OUT2 : ST_IDLE;
      ST_OUT2:    if (out_xfer) state_nxt = ST_IDLE;
      ST_FIN:     if (out_xfer) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // channel outputs
  always_comb begin
    in_ch.ready         = state_r == ST_IDLE;
    out_ch.valid        = 1'b0;
    out_ch.motion_out   = '0;
    out_ch.drive_a      = '0;
    out_ch.drive_b      = '0;
    out_ch.step_done    = 1'b0;
    out_ch.all_finished = 1'b0;
    out_ch.last         = 1'b1;
    case (state_r)
      ST_OUT1: begin
        out_ch.valid      = 1'b1;
        out_ch.motion_out = motion_r;
        out_ch.drive_a    = drive_r[0];
        out_ch.drive_b    = drive_r[1];
        out_ch.last       = !done_r;
      end
      ST_OUT2: begin
        out_ch.valid     = 1'b1;
        out_ch.step_done = 1'b1;
      end
      ST_FIN: begin
        out_ch.valid        = 1'b1;
        out_ch.all_finished = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      running_r <= 1'b0;
      motion_r  <= '0;
      accum_r   <= '0;
      wsel_r    <= 1'b0;
      done_r    <= 1'b0;
      for (int i = 0; i < NREG; i++) cfg_r[i] <= CFG_RESET[i];
      for (int i = 0; i < 2; i++) begin
        prev_enc_r[i] <= '0;
        prev_err_r[i] <= '0;
        integ_r[i]    <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) cfg_r[cfg_ch.index] <= cfg_ch.data;
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (!running_r) begin
              if (in_ch.command == CMD_START) begin
                motion_r  <= in_ch.motion_code;
                running_r <= 1'b1;
                accum_r   <= '0;
                for (int i = 0; i < 2; i++) begin
                  prev_err_r[i] <= '0;
                  integ_r[i]    <= '0;
                end
              end
            end else if (in_ch.command == CMD_TICK) begin
              if (acc_sum >= 17'(MIN_PERIOD_MS)) begin
                accum_r <= '0;
                wsel_r  <= 1'b0;
                done_r  <= 1'b1;
              end else begin
                accum_r <= acc_sum;
              end
            end
          end
        end
        ST_DIV_I: begin
          integ_r[wsel_r] <= integ_new[INT_W-1:0];
        end
        ST_DRIVE: begin
          prev_enc_r[wsel_r] <= enc_cur;
          prev_err_r[wsel_r] <= e_r[ERR_W-1:0];
          done_r             <= done_r & wheel_ok;
          wsel_r             <= !wsel_r;
        end
        ST_OUT1: begin
          if (out_xfer && done_r) running_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          enc_r[0] <= in_ch.encoder_a;
          enc_r[1] <= in_ch.encoder_b;
          ms_r     <= acc_sum;
        end
      end
      ST_PREP: begin
        e_r  <= e_cmb;
        de_r <= de_cmb;
        ds_r <= ds_cmb;
      end
      ST_MUL_D:   p_r     <= e_r[MA_W-1] ? -prod_s : prod_s;
      ST_VT:      ev_r    <= ev_cmb;
      ST_START_I: iprod_r <= prod;
      ST_MUL_KI:  t1_r    <= ev_r[MA_W-1] ? -prod_s : prod_s;
      ST_DRIVE:   drive_r[wsel_r] <= drv[10:0];
      default: begin
      end
    endcase
  end

endmodule
